// File: design/sbdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdl_pkg
// Shared types and constants for the spectrum bin to display level core.
// ----------------------------------------------------------------------------
package sbdl_pkg;

  localparam int BIN_COUNT = 1024;

  localparam logic [1:0] REG_LEVEL_OFFSET = 2'd0;
  localparam logic [1:0] REG_DB_SLOPE     = 2'd1;
  localparam logic [1:0] REG_OUTER_GAIN   = 2'd2;
  localparam logic [1:0] REG_NORM_DB      = 2'd3;

  localparam logic [9:0]  RST_LEVEL_OFFSET = 10'd65;
  localparam logic [12:0] RST_DB_SLOPE     = 13'h1F00;
  localparam logic [9:0]  RST_OUTER_GAIN   = 10'd205;
  localparam logic [15:0] RST_NORM_DB      = 16'd40021;

  localparam logic [17:0] LOG10_2_X10_Q16 = 18'd197283;
  localparam logic [17:0] ZERO_POWER_NEG_DB = 18'd51200;
  localparam logic [15:0] DB10_MAX = 16'd49317;

  typedef struct packed {
    logic        [9:0]  level_offset;
    logic        [12:0] db_slope;
    logic        [9:0]  outer_gain;
    logic        [15:0] norm_db;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic [63:0] p;
  } pwr_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic        zero;
    logic [15:0] db10;
  } db_t;

  typedef struct packed {
    logic [9:0] texel_index;
    logic [7:0] level;
  } res_t;

endpackage

// File: design/spectrum_bin_to_display_level_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bin_to_display_level_core
// Maps complex spectrum bins to clamped log-power display levels.
//
//   channel  handshake               payload
//   bin      bin_valid / bin_stall   bin_index, bin_real, bin_imag
//   level    level_valid / level_stall  texel_index, level
//   config   cfg_write               cfg_index, cfg_data
//
// one beat per cycle while level_stall is low; register stages: 3 power, 11 log, 5 map
// the eight mantissa squaring stages of the log set the depth
// each stage holds its beat while the next is full, bubbles close up
// bin_stall rises only when every stage up to the output holds a beat
// reset clears all stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module spectrum_bin_to_display_level_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               bin_valid,
  output logic               bin_stall,
  input  logic [9:0]         bin_index,
  input  logic signed [31:0] bin_real,
  input  logic signed [31:0] bin_imag,
  output logic               level_valid,
  input  logic               level_stall,
  output logic [9:0]         texel_index,
  output logic [7:0]         level
);
  import sbdl_pkg::*;

  cfg_t cfg;
  pwr_t pwr;
  db_t  db;
  res_t res;

  logic pwr_valid, pwr_ready;
  logic db_valid, db_ready;
  logic bin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_offset <= RST_LEVEL_OFFSET;
      cfg.db_slope     <= RST_DB_SLOPE;
      cfg.outer_gain   <= RST_OUTER_GAIN;
      cfg.norm_db      <= RST_NORM_DB;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEVEL_OFFSET: cfg.level_offset <= cfg_data[9:0];
        REG_DB_SLOPE:     cfg.db_slope     <= cfg_data[12:0];
        REG_OUTER_GAIN:   cfg.outer_gain   <= cfg_data[9:0];
        REG_NORM_DB:      cfg.norm_db      <= cfg_data;
        default: ;
      endcase
    end
  end

  sbdl_power u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bin_valid),
    .in_ready  (bin_ready),
    .bin_index (bin_index),
    .bin_real  (bin_real),
    .bin_imag  (bin_imag),
    .out_valid (pwr_valid),
    .out_ready (pwr_ready),
    .out_data  (pwr)
  );

  sbdl_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pwr_valid),
    .in_ready  (pwr_ready),
    .in_data   (pwr),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_data  (db)
  );

  sbdl_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (db_valid),
    .in_ready  (db_ready),
    .in_data   (db),
    .out_valid (level_valid),
    .out_ready (!level_stall),
    .out_data  (res)
  );

  assign bin_stall   = !bin_ready;
  assign texel_index = res.texel_index;
  assign level       = res.level;

endmodule

// File: design/sbdl_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdl_power
// Magnitudes, squares and sum of one complex bin: three register stages.
// ----------------------------------------------------------------------------
module sbdl_power (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          bin_index,
  input  logic signed [31:0]  bin_real,
  input  logic signed [31:0]  bin_imag,
  output logic                out_valid,
  input  logic                out_ready,
  output sbdl_pkg::pwr_t      out_data
);
  import sbdl_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic [31:0] mag_re_c, mag_im_c;
  logic [31:0] mag_re, mag_im;
  logic [9:0]  idx0, idx1;
  logic [63:0] sq_re_c, sq_im_c;
  logic [63:0] sq_re, sq_im;

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy[NS-1:0]) | ({v[NS-2:0], in_valid} & rdy[NS-1:0]);
    end
  end

  // two's complement magnitude, -2^31 lands on 2^31
  assign mag_re_c = bin_real[31] ? (~bin_real + 32'd1) : bin_real;
  assign mag_im_c = bin_imag[31] ? (~bin_imag + 32'd1) : bin_imag;

  assign sq_re_c = mag_re * mag_re;
  assign sq_im_c = mag_im * mag_im;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mag_re <= mag_re_c;
      mag_im <= mag_im_c;
      idx0   <= bin_index;
    end
    if (rdy[1]) begin
      sq_re <= sq_re_c;
      sq_im <= sq_im_c;
      idx1  <= idx0;
    end
    if (rdy[2]) begin
      out_data.p   <= sq_re + sq_im;
      out_data.idx <= idx1;
    end
  end

endmodule

// File: design/sbdl_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdl_log2
// 10*log10 of the bin power in Q8.8: leading-one stage, normalize stage,
// eight squaring stages for the log2 fraction and a scaling stage.
// ----------------------------------------------------------------------------
module sbdl_log2 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbdl_pkg::pwr_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbdl_pkg::db_t  out_data
);
  import sbdl_pkg::*;

  localparam int NS = 11;
  localparam int LAST_SQ = 9;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic [5:0]  k_c;
  logic [63:0] p0;
  logic [5:0]  k0;
  logic        z0;
  logic [9:0]  idx0;
  logic [63:0] pn_c;

  logic [15:0] m_s   [1:LAST_SQ];
  logic [7:0]  f_s   [1:LAST_SQ];
  logic [5:0]  k_s   [1:LAST_SQ];
  logic        z_s   [1:LAST_SQ];
  logic [9:0]  idx_s [1:LAST_SQ];

  logic [31:0] scale_c;

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy[NS-1:0]) | ({v[NS-2:0], in_valid} & rdy[NS-1:0]);
    end
  end

  // leading one position
  always_comb begin
    k_c = 6'd0;
    for (int b = 0; b < 64; b++) begin
      if (in_data.p[b]) begin
        k_c = 6'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0   <= in_data.p;
      k0   <= k_c;
      z0   <= (in_data.p == 64'd0);
      idx0 <= in_data.idx;
    end
  end

  // mantissa in q1.15: the sixteen bits from the leading one down
  assign pn_c = p0 << (6'd63 - k0);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m_s[1]   <= pn_c[63:48];
      f_s[1]   <= 8'd0;
      k_s[1]   <= k0;
      z_s[1]   <= z0;
      idx_s[1] <= idx0;
    end
  end

  for (genvar j = 2; j <= LAST_SQ; j++) begin : g_sq
    logic [31:0] sq_c;
    logic [16:0] t_c;

    assign sq_c = m_s[j-1] * m_s[j-1];
    assign t_c  = sq_c[31:15];

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        m_s[j]   <= t_c[16] ? t_c[16:1] : t_c[15:0];
        f_s[j]   <= {f_s[j-1][6:0], t_c[16]};
        k_s[j]   <= k_s[j-1];
        z_s[j]   <= z_s[j-1];
        idx_s[j] <= idx_s[j-1];
      end
    end
  end

  assign scale_c = {k_s[LAST_SQ], f_s[LAST_SQ]} * LOG10_2_X10_Q16;

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_data.db10 <= scale_c[31:16];
      out_data.zero <= z_s[LAST_SQ];
      out_data.idx  <= idx_s[LAST_SQ];
    end
  end

  a_norm_msb: assert property (@(posedge clk) disable iff (rst)
    v[1] && !z_s[1] |-> m_s[1][15])
    else $error("normalized mantissa lost its leading one");

  a_sq_msb: assert property (@(posedge clk) disable iff (rst)
    v[LAST_SQ] && !z_s[LAST_SQ] |-> m_s[LAST_SQ][15])
    else $error("squared mantissa left the range 1.0 to 2.0");

  a_db_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.db10 <= DB10_MAX)
    else $error("db value above the largest possible power");

endmodule

// File: design/sbdl_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdl_map
// dB to display level: normalize, slope multiply, offset, gain multiply,
// clamp. Five register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module sbdl_map (
  input  logic           clk,
  input  logic           rst,
  input  sbdl_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbdl_pkg::db_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbdl_pkg::res_t out_data
);
  import sbdl_pkg::*;

  localparam int NS = 5;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic signed [17:0] negdb_c;
  logic signed [17:0] negdb0;
  logic signed [30:0] prod_c;
  logic signed [30:0] prod1;
  logic signed [31:0] rnd_c;
  logic signed [15:0] pix_c;
  logic signed [15:0] pix2;
  logic signed [26:0] g_c;
  logic signed [26:0] g3;
  logic [7:0]         level_c;
  logic               oor_c;
  logic               oor [0:3];
  logic [9:0]         idx [0:3];

  assign rdy[NS] = out_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~rdy[NS-1:0]) | ({v[NS-2:0], in_valid} & rdy[NS-1:0]);
    end
  end

  // negated dB, zero power pinned to -200 dB
  assign negdb_c = in_data.zero ? $signed(ZERO_POWER_NEG_DB)
                 : $signed({2'b00, cfg.norm_db}) - $signed({2'b00, in_data.db10});
  assign oor_c   = ({3'd0, in_data.idx} >= 13'(BIN_COUNT));

  assign prod_c = negdb0 * $signed(cfg.db_slope);

  // divide by 65536 toward zero
  assign rnd_c = 32'(prod1) + (prod1[30] ? 32'sd65535 : 32'sd0);
  assign pix_c = $signed(rnd_c[31:16]) + 16'($signed(cfg.level_offset));

  assign g_c = pix2 * $signed({1'b0, cfg.outer_gain});

  // negative gain product always clamps to zero
  always_comb begin
    if (oor[3] || g3[26]) begin
      level_c = 8'd0;
    end else if (g3[25:16] != 10'd0) begin
      level_c = 8'hFF;
    end else begin
      level_c = g3[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      negdb0 <= negdb_c;
      oor[0] <= oor_c;
      idx[0] <= in_data.idx;
    end
    if (rdy[1]) begin
      prod1  <= prod_c;
      oor[1] <= oor[0];
      idx[1] <= idx[0];
    end
    if (rdy[2]) begin
      pix2   <= pix_c;
      oor[2] <= oor[1];
      idx[2] <= idx[1];
    end
    if (rdy[3]) begin
      g3     <= g_c;
      oor[3] <= oor[2];
      idx[3] <= idx[2];
    end
    if (rdy[4]) begin
      out_data.level       <= level_c;
      out_data.texel_index <= idx[3];
    end
  end

endmodule
